FILE: rtl/dvfs_operating_point_manager_defines.svh
// Assertion macros shared by the RTL. Each use samples on clk and is
// disabled while rst_n is low.
`ifndef DVFS_OPERATING_POINT_MANAGER_DEFINES_SVH
`define DVFS_OPERATING_POINT_MANAGER_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent.
`define DOPM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dopm check failed");

// The consequent holds in the cycle after the antecedent.
`define DOPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dopm check failed");

`else

`define DOPM_ASSERT_SAME(lbl, ante, cons)
`define DOPM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/dopm_pkg.sv
package dopm_pkg;

  localparam int unsigned FREQ_W = 32;
  localparam int unsigned VOLT_W = 16;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned CNT_W  = 5;

  typedef enum logic [1:0] {
    OP_LOAD       = 2'd0,
    OP_SET_FREQ   = 2'd1,
    OP_SET_LIMITS = 2'd2,
    OP_READ       = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PARAM = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // One table entry as stored in the point memory
  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [VOLT_W-1:0] volt;
  } point_t;

  // One command beat
  typedef struct packed {
    opcode_t           opcode;
    logic [IDX_W-1:0]  entry_index;
    logic [FREQ_W-1:0] req_frequency;
    logic [VOLT_W-1:0] req_voltage;
    logic [FREQ_W-1:0] new_minimum;
    logic [FREQ_W-1:0] new_maximum;
  } cmd_t;

  // One result beat
  typedef struct packed {
    status_t           status;
    logic [FREQ_W-1:0] entry_frequency;
    logic [VOLT_W-1:0] entry_voltage;
    logic [IDX_W-1:0]  current_index;
    logic [FREQ_W-1:0] current_frequency;
    logic [VOLT_W-1:0] current_voltage;
    logic [FREQ_W-1:0] limit_minimum;
    logic [FREQ_W-1:0] limit_maximum;
    logic              level_changed;
  } res_t;

endpackage

FILE: rtl/dvfs_operating_point_manager.sv
// Channel   Dir  Beat contents
// in_*      in   one command: opcode in tuser, operands in tdata
// out_*     out  one result per command: status and change flag in tuser
// cfg_*     in   entry_count register write, always ready
//
// Load and out-of-range commands go straight to reading the current point; a
// read first fetches the addressed entry; set-limits reads the current point,
// then it and set-frequency search the live entries (entry_count saturated to
// TABLE_DEPTH), one entry a cycle through the point memory's read port.
// A finished result waits in the output register while the next command is
// accepted. rst_n is synchronous; the table is undefined until loaded and
// has no clearing pass, limits reset to zero and all ones, the point to 0.
module dvfs_operating_point_manager #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // entry_index[3:0], req_frequency[35:4], req_voltage[51:36],
  // new_minimum[83:52], new_maximum[115:84]
  input  logic [119:0] in_tdata,
  // opcode[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // entry_frequency[31:0], entry_voltage[47:32], current_index[51:48],
  // current_frequency[83:52], current_voltage[99:84], limit_minimum[131:100],
  // limit_maximum[163:132]
  output logic [167:0] out_tdata,
  // status[1:0], level_changed[2]
  output logic [2:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [4:0]   cfg_data
);

  localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [dopm_pkg::CNT_W-1:0] cfg_count_r;
  logic [CNT_W-1:0]           live_cnt;
  dopm_pkg::cmd_t             cmd;
  logic                       mem_we;
  logic                       mem_re;
  logic [AW-1:0]              mem_addr;
  dopm_pkg::point_t           mem_wdata;
  dopm_pkg::point_t           mem_rdata;
  logic                       res_rdy;
  logic                       res_vld;
  dopm_pkg::res_t             res;
  logic                       out_vld_r;
  dopm_pkg::res_t             out_res_r;

  // Hold the entry count; writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= dopm_pkg::CNT_W'(1);
    end else if (cfg_valid) begin
      cfg_count_r <= cfg_data;
    end
  end

  // Saturate the count to the table depth
  assign live_cnt = (32'(cfg_count_r) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                          : CNT_W'(cfg_count_r);

  // Unpack the command beat
  always_comb begin
    cmd.opcode        = dopm_pkg::opcode_t'(in_tuser);
    cmd.entry_index   = in_tdata[3:0];
    cmd.req_frequency = in_tdata[35:4];
    cmd.req_voltage   = in_tdata[51:36];
    cmd.new_minimum   = in_tdata[83:52];
    cmd.new_maximum   = in_tdata[115:84];
  end

  dopm_point_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  dopm_seq #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .CNT_W (CNT_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cmd       (cmd),
    .live_cnt  (live_cnt),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .res_rdy   (res_rdy),
    .res_vld   (res_vld),
    .res       (res)
  );

  // Output register: free when empty or draining this cycle
  assign res_rdy = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_res_r <= res;
    end
  end

  // Pack the result beat
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0, out_res_r.limit_maximum, out_res_r.limit_minimum,
                       out_res_r.current_voltage, out_res_r.current_frequency,
                       out_res_r.current_index, out_res_r.entry_voltage,
                       out_res_r.entry_frequency};
  assign out_tuser  = {out_res_r.level_changed, out_res_r.status};

endmodule

FILE: rtl/dopm_point_mem.sv
module dopm_point_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [AW-1:0]     addr,
  input  dopm_pkg::point_t  wdata,
  output dopm_pkg::point_t  rdata
);

  dopm_pkg::point_t mem_r [DEPTH];
  dopm_pkg::point_t rd_data_r;

  // Write one entry; read data is registered and held between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem_r[addr];
    end
  end

  assign rdata = rd_data_r;

endmodule

FILE: rtl/dopm_seq.sv
`include "dvfs_operating_point_manager_defines.svh"

module dopm_seq #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned CNT_W = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dopm_pkg::cmd_t    cmd,
  input  logic [CNT_W-1:0]  live_cnt,
  output logic              mem_we,
  output logic              mem_re,
  output logic [AW-1:0]     mem_addr,
  output dopm_pkg::point_t  mem_wdata,
  input  dopm_pkg::point_t  mem_rdata,
  input  logic              res_rdy,
  output logic              res_vld,
  output dopm_pkg::res_t    res
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CMD   = 8'b0000_0010,
    S_ENTRY = 8'b0000_0100,
    S_ACT   = 8'b0000_1000,
    S_SCAN  = 8'b0001_0000,
    S_EVAL  = 8'b0010_0000,
    S_CUR   = 8'b0100_0000,
    S_WB    = 8'b1000_0000
  } state_t;

  state_t                 state_r, state_nxt;
  dopm_pkg::cmd_t         cmd_r, cmd_nxt;
  logic [CNT_W-1:0]       scan_r, scan_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]          cmp_idx_r, cmp_idx_nxt;
  logic                   hit_a_r, hit_a_nxt;
  logic [AW-1:0]          hit_a_idx_r, hit_a_idx_nxt;
  logic                   hit_b_r, hit_b_nxt;
  logic [AW-1:0]          hit_b_idx_r, hit_b_idx_nxt;
  logic [AW-1:0]          act_r, act_nxt;
  logic [31:0]            lo_r, lo_nxt;
  logic [31:0]            hi_r, hi_nxt;
  logic [31:0]            cur_freq_r, cur_freq_nxt;
  dopm_pkg::status_t      status_r, status_nxt;
  logic                   chg_r, chg_nxt;
  logic [31:0]            efreq_r, efreq_nxt;
  logic [15:0]            evolt_r, evolt_nxt;

  logic                   idx_in_depth;
  logic                   idx_in_live;
  logic [31:0]            tgt_a;
  logic [AW-1:0]          act_pick;

  assign in_ready     = (state_r == S_IDLE);
  assign idx_in_depth = 32'(cmd_r.entry_index) < 32'(DEPTH);
  assign idx_in_live  = 32'(cmd_r.entry_index) < 32'(live_cnt);
  assign tgt_a        = (cmd_r.opcode == dopm_pkg::OP_SET_FREQ) ? cmd_r.req_frequency
                                                                : cmd_r.new_minimum;

  // Clamp target for a limit change: move only when the point violates a limit
  always_comb begin
    act_pick = act_r;
    if (cur_freq_r < cmd_r.new_minimum) begin
      act_pick = hit_a_idx_r;
    end else if (cur_freq_r > cmd_r.new_maximum) begin
      act_pick = hit_b_idx_r;
    end
  end

  // Sequence one command through the point memory
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    scan_nxt      = scan_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    hit_a_nxt     = hit_a_r;
    hit_a_idx_nxt = hit_a_idx_r;
    hit_b_nxt     = hit_b_r;
    hit_b_idx_nxt = hit_b_idx_r;
    act_nxt       = act_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cur_freq_nxt  = cur_freq_r;
    status_nxt    = status_r;
    chg_nxt       = chg_r;
    efreq_nxt     = efreq_r;
    evolt_nxt     = evolt_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = '0;
    mem_wdata     = '{freq: cmd_r.req_frequency, volt: cmd_r.req_voltage};
    res_vld       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = cmd;
          status_nxt  = dopm_pkg::ST_OK;
          chg_nxt     = 1'b0;
          efreq_nxt   = '0;
          evolt_nxt   = '0;
          scan_nxt    = '0;
          cmp_vld_nxt = 1'b0;
          hit_a_nxt   = 1'b0;
          hit_b_nxt   = 1'b0;
          state_nxt   = S_CMD;
        end
      end
      S_CMD: begin
        unique case (cmd_r.opcode)
          dopm_pkg::OP_LOAD: begin
            if (idx_in_depth) begin
              mem_we   = 1'b1;
              mem_addr = AW'(cmd_r.entry_index);
            end else begin
              status_nxt = dopm_pkg::ST_PARAM;
            end
            state_nxt = S_CUR;
          end
          dopm_pkg::OP_SET_FREQ: begin
            if (cmd_r.req_frequency == '0) begin
              status_nxt = dopm_pkg::ST_RANGE;
              state_nxt  = S_CUR;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          dopm_pkg::OP_SET_LIMITS: begin
            if (cmd_r.new_minimum > cmd_r.new_maximum || cmd_r.new_minimum == '0 ||
                cmd_r.new_maximum == '0) begin
              status_nxt = dopm_pkg::ST_PARAM;
              state_nxt  = S_CUR;
            end else begin
              mem_re    = 1'b1;
              mem_addr  = act_r;
              state_nxt = S_ACT;
            end
          end
          dopm_pkg::OP_READ: begin
            if (idx_in_live) begin
              mem_re    = 1'b1;
              mem_addr  = AW'(cmd_r.entry_index);
              state_nxt = S_ENTRY;
            end else begin
              status_nxt = dopm_pkg::ST_PARAM;
              state_nxt  = S_CUR;
            end
          end
          default: state_nxt = S_CUR;
        endcase
      end
      S_ENTRY: begin
        efreq_nxt = mem_rdata.freq;
        evolt_nxt = mem_rdata.volt;
        state_nxt = S_CUR;
      end
      S_ACT: begin
        cur_freq_nxt = mem_rdata.freq;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        // Compare the entry read last cycle; keep the first match
        if (cmp_vld_r) begin
          if (!hit_a_r && mem_rdata.freq == tgt_a) begin
            hit_a_nxt     = 1'b1;
            hit_a_idx_nxt = cmp_idx_r;
          end
          if (!hit_b_r && mem_rdata.freq == cmd_r.new_maximum) begin
            hit_b_nxt     = 1'b1;
            hit_b_idx_nxt = cmp_idx_r;
          end
        end
        // Issue the next read, one entry a cycle
        if (scan_r < live_cnt) begin
          mem_re      = 1'b1;
          mem_addr    = scan_r[AW-1:0];
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_r[AW-1:0];
          scan_nxt    = scan_r + CNT_W'(1);
        end else begin
          cmp_vld_nxt = 1'b0;
          if (!cmp_vld_r) begin
            state_nxt = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (cmd_r.opcode == dopm_pkg::OP_SET_FREQ) begin
          if (!hit_a_r || cmd_r.req_frequency < lo_r || cmd_r.req_frequency > hi_r) begin
            status_nxt = dopm_pkg::ST_RANGE;
          end else begin
            act_nxt = hit_a_idx_r;
            chg_nxt = (hit_a_idx_r != act_r);
          end
        end else begin
          if (!hit_a_r || !hit_b_r) begin
            status_nxt = dopm_pkg::ST_PARAM;
          end else begin
            act_nxt = act_pick;
            chg_nxt = (act_pick != act_r);
            lo_nxt  = cmd_r.new_minimum;
            hi_nxt  = cmd_r.new_maximum;
          end
        end
        state_nxt = S_CUR;
      end
      S_CUR: begin
        mem_re    = 1'b1;
        mem_addr  = act_r;
        state_nxt = S_WB;
      end
      S_WB: begin
        // Hold the read data until the output slot frees up
        if (res_rdy) begin
          res_vld   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      act_r   <= '0;
      lo_r    <= '0;
      hi_r    <= '1;
    end else begin
      state_r <= state_nxt;
      act_r   <= act_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    scan_r      <= scan_nxt;
    cmp_vld_r   <= cmp_vld_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    hit_a_r     <= hit_a_nxt;
    hit_a_idx_r <= hit_a_idx_nxt;
    hit_b_r     <= hit_b_nxt;
    hit_b_idx_r <= hit_b_idx_nxt;
    cur_freq_r  <= cur_freq_nxt;
    status_r    <= status_nxt;
    chg_r       <= chg_nxt;
    efreq_r     <= efreq_nxt;
    evolt_r     <= evolt_nxt;
  end

  // Assemble the result from the registered memory read of the current point
  always_comb begin
    res.status            = status_r;
    res.entry_frequency   = efreq_r;
    res.entry_voltage     = evolt_r;
    res.current_index     = 4'(act_r);
    res.current_frequency = mem_rdata.freq;
    res.current_voltage   = mem_rdata.volt;
    res.limit_minimum     = lo_r;
    res.limit_maximum     = hi_r;
    res.level_changed     = chg_r;
  end

  `DOPM_ASSERT_SAME(a_wr_only_load, mem_we, state_r == S_CMD && cmd_r.opcode == dopm_pkg::OP_LOAD)
  `DOPM_ASSERT_SAME(a_no_wr_rd_same, mem_we, !mem_re)
  `DOPM_ASSERT_SAME(a_push_when_free, res_vld, res_rdy)
  `DOPM_ASSERT_SAME(a_chg_needs_ok, res_vld && res.level_changed, res.status == dopm_pkg::ST_OK && (cmd_r.opcode == dopm_pkg::OP_SET_FREQ || cmd_r.opcode == dopm_pkg::OP_SET_LIMITS))
  `DOPM_ASSERT_NEXT(a_idle_after_push, res_vld, state_r == S_IDLE)

endmodule

FILE: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dopm_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned MAX_PRINTED = 40;

  // Track the operating point table, limits and current point; hold the results still owed
  class op_point_tracker;
    logic [FREQ_W-1:0] freq_tab [DEPTH];
    logic [VOLT_W-1:0] volt_tab [DEPTH];
    logic [IDX_W-1:0]  cur_point;
    logic [FREQ_W-1:0] lower_lim;
    logic [FREQ_W-1:0] upper_lim;
    logic [CNT_W-1:0]  entry_count;
    res_t              due_results [$];
    int                fails;

    function new();
      cur_point = '0;
      lower_lim = '0;
      upper_lim = '1;
      entry_count = 5'd1;
      fails = 0;
    endfunction

    function int live_entries();
      return (entry_count > DEPTH) ? DEPTH : int'(entry_count);
    endfunction

    // First entry below the live count that holds frequency f, or -1
    function int find_freq(logic [FREQ_W-1:0] f);
      for (int i = 0; i < live_entries(); i++)
        if (freq_tab[i] == f) return i;
      return -1;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void set_count(logic [CNT_W-1:0] v);
      entry_count = v;
    endfunction

    // Apply one accepted command and queue the result it owes
    function void apply_command(cmd_t c);
      res_t r;
      logic [IDX_W-1:0] was;
      logic [FREQ_W-1:0] cf;
      int hit;
      int lo_hit;
      int hi_hit;
      r = '0;
      r.status = ST_OK;
      was = cur_point;
      case (c.opcode)
        OP_LOAD: begin
          freq_tab[c.entry_index] = c.req_frequency;
          volt_tab[c.entry_index] = c.req_voltage;
        end
        OP_SET_FREQ: begin
          hit = find_freq(c.req_frequency);
          if (c.req_frequency == '0 || hit < 0 || c.req_frequency < lower_lim ||
              c.req_frequency > upper_lim)
            r.status = ST_RANGE;
          else
            cur_point = IDX_W'(hit);
        end
        OP_SET_LIMITS: begin
          lo_hit = find_freq(c.new_minimum);
          hi_hit = find_freq(c.new_maximum);
          if (c.new_minimum > c.new_maximum || c.new_minimum == '0 ||
              c.new_maximum == '0 || lo_hit < 0 || hi_hit < 0) begin
            r.status = ST_PARAM;
          end else begin
            // Clamp the current point onto the violated limit
            cf = freq_tab[cur_point];
            if (cf < c.new_minimum)
              cur_point = IDX_W'(lo_hit);
            else if (cf > c.new_maximum)
              cur_point = IDX_W'(hi_hit);
            lower_lim = c.new_minimum;
            upper_lim = c.new_maximum;
          end
        end
        default: begin
          if (int'(c.entry_index) < live_entries()) begin
            r.entry_frequency = freq_tab[c.entry_index];
            r.entry_voltage = volt_tab[c.entry_index];
          end else begin
            r.status = ST_PARAM;
          end
        end
      endcase
      r.current_index = cur_point;
      r.current_frequency = freq_tab[cur_point];
      r.current_voltage = volt_tab[cur_point];
      r.limit_minimum = lower_lim;
      r.limit_maximum = upper_lim;
      r.level_changed = (cur_point != was);
      due_results.push_back(r);
    endfunction

    task report(string msg);
      fails++;
      if (fails <= MAX_PRINTED) $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task cmp_field(string what, logic [FREQ_W-1:0] got, logic [FREQ_W-1:0] want);
      if (got !== want) report($sformatf("%s: got %0h, want %0h", what, got, want));
    endtask

    // Compare one result beat against the oldest owed result
    task match_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        report("result beat with nothing owed");
        return;
      end
      want = due_results.pop_front();
      cmp_field("status", 32'(got.status), 32'(want.status));
      cmp_field("entry_frequency", got.entry_frequency, want.entry_frequency);
      cmp_field("entry_voltage", 32'(got.entry_voltage), 32'(want.entry_voltage));
      cmp_field("current_index", 32'(got.current_index), 32'(want.current_index));
      cmp_field("current_frequency", got.current_frequency, want.current_frequency);
      cmp_field("current_voltage", 32'(got.current_voltage), 32'(want.current_voltage));
      cmp_field("limit_minimum", got.limit_minimum, want.limit_minimum);
      cmp_field("limit_maximum", got.limit_maximum, want.limit_maximum);
      cmp_field("level_changed", 32'(got.level_changed), 32'(want.level_changed));
    endtask
  endclass

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [119:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [167:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [4:0]   cfg_data = '0;

  op_point_tracker tracker;
  bit calm = 1'b0;
  int unsigned cycles = 0;

  logic [FREQ_W-1:0] freq_pool [12] = '{
    32'd1, 32'd24000000, 32'd100000000, 32'd250000000, 32'd400000000, 32'd600000000,
    32'd800000000, 32'd1000000000, 32'd1500000000, 32'd2000000000, 32'd3000000000,
    32'hFFFF_FFFF
  };

  logic [CNT_W-1:0] count_plan [10] = '{
    5'd16, 5'd0, 5'd31, 5'd5, 5'd1, 5'd16, 5'd20, 5'd8, 5'd12, 5'd16
  };

  dvfs_operating_point_manager i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, none in a calm phase
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic cmd_t mk_cmd(opcode_t op, logic [IDX_W-1:0] idx, logic [FREQ_W-1:0] f,
                                  logic [VOLT_W-1:0] v, logic [FREQ_W-1:0] mn,
                                  logic [FREQ_W-1:0] mx);
    cmd_t c;
    c.opcode = op;
    c.entry_index = idx;
    c.req_frequency = f;
    c.req_voltage = v;
    c.new_minimum = mn;
    c.new_maximum = mx;
    return c;
  endfunction

  function automatic logic [FREQ_W-1:0] table_freq();
    return tracker.freq_tab[$urandom_range(0, DEPTH - 1)];
  endfunction

  // Random command: unused fields stay random, used ones mostly hit the table
  function automatic cmd_t next_cmd();
    cmd_t c;
    int r;
    int sel;
    logic [FREQ_W-1:0] a;
    logic [FREQ_W-1:0] b;
    c = mk_cmd(OP_READ, IDX_W'($urandom), $urandom, VOLT_W'($urandom), $urandom, $urandom);
    r = $urandom_range(0, 99);
    sel = $urandom_range(0, 99);
    if (r < 25) begin
      c.opcode = OP_LOAD;
      if (sel < 60) c.req_frequency = freq_pool[$urandom_range(0, 11)];
      else if (sel < 68) c.req_frequency = '0;
      else if (sel < 75) c.req_frequency = '1;
    end else if (r < 55) begin
      c.opcode = OP_SET_FREQ;
      if (sel < 70) c.req_frequency = table_freq();
      else if (sel < 85) c.req_frequency = freq_pool[$urandom_range(0, 11)];
      else if (sel < 92) c.req_frequency = '0;
    end else if (r < 80) begin
      c.opcode = OP_SET_LIMITS;
      a = table_freq();
      b = table_freq();
      if (sel < 55) begin
        c.new_minimum = (a < b) ? a : b;
        c.new_maximum = (a < b) ? b : a;
      end else if (sel < 65) begin
        c.new_minimum = freq_pool[0];
        c.new_maximum = freq_pool[11];
      end else if (sel < 75) begin
        c.new_minimum = (a < b) ? b : a;
        c.new_maximum = (a < b) ? a : b;
      end else if (sel < 80) begin
        c.new_minimum = '0;
        c.new_maximum = b;
      end else if (sel < 85) begin
        c.new_minimum = a;
        c.new_maximum = '0;
      end else if (sel < 92) begin
        c.new_minimum = a;
      end
    end
    return c;
  endfunction

  // Drive one command beat and note it at its handshake
  task automatic send_cmd(input cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, c.new_maximum, c.new_minimum, c.req_voltage, c.req_frequency,
                 c.entry_index};
    in_tuser <= c.opcode;
    do @(posedge clk); while (!in_tready);
    tracker.apply_command(c);
  endtask

  // Drop valid and wait for every owed result
  task automatic drain();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_count(v);
  endtask

  // Result side: random backpressure, check every accepted beat
  initial begin : result_sink
    res_t got;
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.status = status_t'(out_tuser[1:0]);
        got.level_changed = out_tuser[2];
        got.entry_frequency = out_tdata[31:0];
        got.entry_voltage = out_tdata[47:32];
        got.current_index = out_tdata[51:48];
        got.current_frequency = out_tdata[83:52];
        got.current_voltage = out_tdata[99:84];
        got.limit_minimum = out_tdata[131:100];
        got.limit_maximum = out_tdata[163:132];
        tracker.match_result(got);
      end
      if (calm) begin
        out_tready <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else if (out_tready) begin
        if ($urandom_range(0, 99) < 35) begin
          out_tready <= 1'b0;
          hold = pick_gap();
        end else begin
          hold = $urandom_range(0, 6);
        end
      end else begin
        out_tready <= 1'b1;
        hold = $urandom_range(0, 6);
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("dvfs_operating_point_manager verification failed");
    $finish;
  end

  initial begin : stimulus
    tracker = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole table first; the last four entries repeat earlier frequencies
    for (int i = 0; i < DEPTH; i++)
      send_cmd(mk_cmd(OP_LOAD, IDX_W'(i), freq_pool[i % 12],
                      (i == 0) ? 16'h0000 : (i == DEPTH - 1) ? 16'hFFFF : VOLT_W'(900 + 25 * i),
                      '0, '0));

    // Reset count is one entry
    send_cmd(mk_cmd(OP_READ, 4'd0, '0, '0, '0, '0));
    send_cmd(mk_cmd(OP_READ, 4'd1, '0, '0, '0, '0));
    drain();
    write_count(5'd16);

    // Requests, bad limits, clamps both ways, rewrite of the current point
    send_cmd(mk_cmd(OP_SET_FREQ, '0, freq_pool[5], '0, '0, '0));
    send_cmd(mk_cmd(OP_SET_FREQ, '0, '0, '0, '0, '0));
    send_cmd(mk_cmd(OP_SET_FREQ, '0, 32'd12345, '0, '0, '0));
    send_cmd(mk_cmd(OP_SET_LIMITS, '0, '0, '0, freq_pool[7], freq_pool[3]));
    send_cmd(mk_cmd(OP_SET_LIMITS, '0, '0, '0, '0, freq_pool[7]));
    send_cmd(mk_cmd(OP_SET_LIMITS, '0, '0, '0, 32'd777, freq_pool[9]));
    send_cmd(mk_cmd(OP_SET_LIMITS, '0, '0, '0, freq_pool[6], freq_pool[9]));
    send_cmd(mk_cmd(OP_SET_FREQ, '0, freq_pool[10], '0, '0, '0));
    send_cmd(mk_cmd(OP_SET_LIMITS, '0, '0, '0, freq_pool[2], freq_pool[4]));
    send_cmd(mk_cmd(OP_LOAD, 4'd4, 32'hFFFF_FFFF, 16'hFFFF, '0, '0));
    send_cmd(mk_cmd(OP_READ, 4'd4, '0, '0, '0, '0));

    // Random phases, each under its own entry count, some without idling
    count_plan[7] = CNT_W'($urandom_range(1, 16));
    for (int p = 0; p < 10; p++) begin
      drain();
      calm = (p % 4 == 3);
      write_count(count_plan[p]);
      repeat (110) send_cmd(next_cmd());
    end

    calm = 1'b0;
    drain();
    repeat (30) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.pending()));
    if (tracker.fails == 0)
      $display("dvfs_operating_point_manager verification clean");
    else
      $display("dvfs_operating_point_manager verification failed");
    $finish;
  end

endmodule
